/* src/mfc_pkg.sv */
// Shared types, constants and control structs for the miss fill coalescer.
package mfc_pkg;

	localparam int PENDING_KEYS    = 8;
	localparam int WAITERS_PER_KEY = 8;

	localparam int KEY_W  = (PENDING_KEYS > 1) ? $clog2(PENDING_KEYS) : 1;
	localparam int WIX_W  = (WAITERS_PER_KEY > 1) ? $clog2(WAITERS_PER_KEY) : 1;
	localparam int CNT_W  = $clog2(WAITERS_PER_KEY + 1);
	localparam int WDEPTH = PENDING_KEYS * WAITERS_PER_KEY;
	localparam int ADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

	localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd3;

	typedef enum logic [2:0] {
		OP_LOOKUP    = 3'd0,
		OP_FILL_OK   = 3'd1,
		OP_FILL_FAIL = 3'd2,
		OP_CANCEL    = 3'd3,
		OP_RELEASE   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_YOU_FILL = 2'd1,
		ST_TIMEOUT  = 2'd2,
		ST_CANCEL   = 2'd3
	} status_t;

	typedef enum logic {
		SRC_REQ   = 1'b0,
		SRC_RDATA = 1'b1
	} emit_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_DR_RD,
		S_DR_EMIT,
		S_SEL_RD,
		S_SEL_EV,
		S_SEL_PICK,
		S_SEL_PRD,
		S_SEL_EMIT,
		S_SH_RD,
		S_SH_WR,
		S_CN_RD,
		S_CN_EV
	} state_t;

	typedef struct packed {
		logic      load;
		logic      alloc;
		logic      enqueue;
		logic      free_key;
		logic      dec_count;
		logic      inc_attempt;
		logic      idx_clr;
		logic      idx_inc;
		logic      idx_to_best;
		logic      rd_next;
		logic      shift_wr;
		logic      best_clr;
		logic      best_upd;
		logic      emit;
		emit_src_t emit_src;
		status_t   emit_st;
		logic      emit_last;
	} mfc_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       store_hit;
		logic       key_found;
		logic       table_full;
		logic       expired;
		logic       list_full;
		logic       att_ok;
		logic       idx_lt_cnt;
		logic       idx_last;
		logic       idx_next_lt;
		logic       best_found;
		logic       match;
		logic       out_free;
	} mfc_stat_t;

endpackage

/* src/mfc_dp.sv */
// Datapath: item registers, key table, waiter memory, scan registers and result register.
module mfc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mfc_pkg::mfc_cmd_t   cmd,
	output mfc_pkg::mfc_stat_t  stat,
	input  logic                cfg_wr_en,
	input  logic [3:0]          cfg_wr_data,
	input  logic [2:0]          op,
	input  logic [31:0]         key_tag,
	input  logic                store_hit,
	input  logic [31:0]         deadline,
	input  logic [31:0]         current_time,
	input  logic [7:0]          requester,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          target,
	output logic [1:0]          status,
	output logic                last
);
	import mfc_pkg::*;

	typedef struct packed {
		logic [7:0]  ident;
		logic [31:0] dl;
	} waiter_t;

	logic [3:0]  max_att_q;
	logic [2:0]  op_q;
	logic [31:0] tag_q;
	logic        hit_q;
	logic [31:0] dl_q;
	logic [31:0] now_q;
	logic [7:0]  req_q;

	logic [PENDING_KEYS-1:0] key_valid_q;
	logic [31:0]             key_tag_q [PENDING_KEYS];
	logic [3:0]              attempt_q [PENDING_KEYS];
	logic [CNT_W-1:0]        wcount_q  [PENDING_KEYS];

	waiter_t     mem [WDEPTH];
	waiter_t     rdata_q;

	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] best_q;
	logic [31:0]      best_dl_q;
	logic             best_found_q;

	logic        out_valid_q;
	logic [7:0]  target_q;
	logic [1:0]  status_q;
	logic        last_q;

	logic [KEY_W-1:0] match_idx, free_idx, kidx;
	logic             found, has_free;
	logic [CNT_W-1:0] cnt, idx_p1;
	logic [ADDR_W-1:0] base, raddr, waddr;
	logic [WIX_W-1:0] rd_ix;
	logic             live;

	always_comb begin
		found     = 1'b0;
		has_free  = 1'b0;
		match_idx = '0;
		free_idx  = '0;
		for (int k = PENDING_KEYS - 1; k >= 0; k--) begin
			if (key_valid_q[k] && key_tag_q[k] == tag_q) begin
				found     = 1'b1;
				match_idx = KEY_W'(k);
			end
			if (!key_valid_q[k]) begin
				has_free = 1'b1;
				free_idx = KEY_W'(k);
			end
		end
	end

	assign kidx   = found ? match_idx : free_idx;
	assign cnt    = wcount_q[kidx];
	assign idx_p1 = idx_q + CNT_W'(1);
	assign base   = ADDR_W'(kidx) * ADDR_W'(WAITERS_PER_KEY);
	assign rd_ix  = cmd.rd_next ? idx_p1[WIX_W-1:0] : idx_q[WIX_W-1:0];
	assign raddr  = base + ADDR_W'(rd_ix);
	assign waddr  = cmd.enqueue ? base + ADDR_W'(cnt[WIX_W-1:0])
	                            : base + ADDR_W'(idx_q[WIX_W-1:0]);
	assign live   = rdata_q.dl > now_q;

	assign stat.op          = op_q;
	assign stat.store_hit   = hit_q;
	assign stat.key_found   = found;
	assign stat.table_full  = !has_free;
	assign stat.expired     = now_q >= dl_q;
	assign stat.list_full   = cnt >= CNT_W'(WAITERS_PER_KEY);
	assign stat.att_ok      = attempt_q[kidx] < max_att_q;
	assign stat.idx_lt_cnt  = idx_q < cnt;
	assign stat.idx_last    = idx_p1 == cnt;
	assign stat.idx_next_lt = idx_p1 < cnt;
	assign stat.best_found  = best_found_q;
	assign stat.match       = rdata_q.ident == req_q;
	assign stat.out_free    = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_att_q <= MAX_ATTEMPTS_RST;
		end else if (cfg_wr_en) begin
			max_att_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			tag_q <= key_tag;
			hit_q <= store_hit;
			dl_q  <= deadline;
			now_q <= current_time;
			req_q <= requester;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= '0;
			for (int k = 0; k < PENDING_KEYS; k++) begin
				wcount_q[k] <= '0;
			end
		end else begin
			if (cmd.alloc) begin
				key_valid_q[kidx] <= 1'b1;
				wcount_q[kidx]    <= '0;
			end
			if (cmd.enqueue) begin
				wcount_q[kidx] <= cnt + CNT_W'(1);
			end
			if (cmd.dec_count) begin
				wcount_q[kidx] <= cnt - CNT_W'(1);
			end
			if (cmd.free_key) begin
				key_valid_q[kidx] <= 1'b0;
				wcount_q[kidx]    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			key_tag_q[kidx] <= tag_q;
			attempt_q[kidx] <= 4'd1;
		end
		if (cmd.inc_attempt) begin
			attempt_q[kidx] <= attempt_q[kidx] + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enqueue) begin
			mem[waddr] <= '{ident: req_q, dl: dl_q};
		end else if (cmd.shift_wr) begin
			mem[waddr] <= rdata_q;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_p1;
		end else if (cmd.idx_to_best) begin
			idx_q <= best_q;
		end
	end

	// Only live waiters compete; ties keep the earliest entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (cmd.best_clr) begin
			best_found_q <= 1'b0;
		end else if (cmd.best_upd && live && (!best_found_q || rdata_q.dl > best_dl_q)) begin
			best_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.best_upd && live && (!best_found_q || rdata_q.dl > best_dl_q)) begin
			best_q    <= idx_q;
			best_dl_q <= rdata_q.dl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			target_q <= (cmd.emit_src == SRC_REQ) ? req_q : rdata_q.ident;
			status_q <= cmd.emit_st;
			last_q   <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign target    = target_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

/* src/mfc_ctrl.sv */
// Controller: sequences decode, list drains, filler selection, cancel search and list compaction.
module mfc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mfc_pkg::mfc_stat_t  stat,
	output mfc_pkg::mfc_cmd_t   cmd
);
	import mfc_pkg::*;

	state_t  state_q, state_d;
	status_t drain_st_q, drain_st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			drain_st_q <= ST_HIT;
		end else begin
			state_q    <= state_d;
			drain_st_q <= drain_st_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		drain_st_d = drain_st_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.emit_src  = SRC_REQ;
		cmd.emit_st   = ST_HIT;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.idx_clr  = 1'b1;
				cmd.best_clr = 1'b1;
				priority if (stat.op == OP_LOOKUP) begin
					cmd.emit_src  = SRC_REQ;
					cmd.emit_last = 1'b1;
					priority if (stat.store_hit) begin
						cmd.emit_st = ST_HIT;
						cmd.emit    = stat.out_free;
					end else if (!stat.key_found) begin
						cmd.emit_st = stat.table_full ? ST_TIMEOUT : ST_YOU_FILL;
						cmd.emit    = stat.out_free;
						cmd.alloc   = stat.out_free && !stat.table_full;
					end else if (stat.expired || stat.list_full) begin
						cmd.emit_st = ST_TIMEOUT;
						cmd.emit    = stat.out_free;
					end else begin
						cmd.enqueue = 1'b1;
					end
					if (cmd.emit || cmd.enqueue) begin
						state_d = S_IDLE;
					end
				end else if (!stat.key_found) begin
					state_d = S_IDLE;
				end else if (stat.op == OP_FILL_OK) begin
					drain_st_d = ST_HIT;
					state_d    = S_DR_RD;
				end else if (stat.op == OP_RELEASE) begin
					drain_st_d = ST_TIMEOUT;
					state_d    = S_DR_RD;
				end else if (stat.op == OP_FILL_FAIL) begin
					drain_st_d = ST_TIMEOUT;
					state_d    = stat.att_ok ? S_SEL_RD : S_DR_RD;
				end else if (stat.op == OP_CANCEL) begin
					state_d = S_CN_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DR_RD: begin
				if (stat.idx_lt_cnt) begin
					state_d = S_DR_EMIT;
				end else begin
					cmd.free_key = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_DR_EMIT: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_src  = SRC_RDATA;
					cmd.emit_st   = drain_st_q;
					cmd.emit_last = stat.idx_last;
					cmd.idx_inc   = 1'b1;
					if (stat.idx_last) begin
						cmd.free_key = 1'b1;
						state_d      = S_IDLE;
					end else begin
						state_d = S_DR_RD;
					end
				end
			end
			S_SEL_RD: begin
				priority if (stat.idx_lt_cnt) begin
					state_d = S_SEL_EV;
				end else if (stat.best_found) begin
					state_d = S_SEL_PICK;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = S_DR_RD;
				end
			end
			S_SEL_EV: begin
				cmd.best_upd = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_SEL_RD;
			end
			S_SEL_PICK: begin
				cmd.idx_to_best = 1'b1;
				state_d         = S_SEL_PRD;
			end
			S_SEL_PRD: begin
				state_d = S_SEL_EMIT;
			end
			S_SEL_EMIT: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_src    = SRC_RDATA;
					cmd.emit_st     = ST_YOU_FILL;
					cmd.emit_last   = 1'b1;
					cmd.inc_attempt = 1'b1;
					state_d         = S_SH_RD;
				end
			end
			S_SH_RD: begin
				if (stat.idx_next_lt) begin
					cmd.rd_next = 1'b1;
					state_d     = S_SH_WR;
				end else begin
					cmd.dec_count = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_SH_WR: begin
				cmd.shift_wr = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_SH_RD;
			end
			S_CN_RD: begin
				state_d = stat.idx_lt_cnt ? S_CN_EV : S_IDLE;
			end
			S_CN_EV: begin
				if (stat.match) begin
					if (stat.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_src  = SRC_REQ;
						cmd.emit_st   = ST_CANCEL;
						cmd.emit_last = 1'b1;
						state_d       = S_SH_RD;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_CN_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* src/miss_fill_coalescer.sv */
// Top level of the miss fill coalescer: controller plus datapath.
//
//   channel  | signals                                   | transfer
//   ---------+-------------------------------------------+---------------------------
//   input    | in_valid/in_ready, op .. requester        | valid & ready at clk rise
//   output   | out_valid/out_ready, target status last   | valid & ready at clk rise
//   config   | cfg_wr_en, cfg_wr_data                    | write when cfg_wr_en high
//
// One word at a time: a lookup answers or enqueues from decode; a drain of n waiters reads
// and answers each in turn, then frees the key, also with an empty list; fill failure scans
// the list, picks and answers the new filler and shifts each later entry down, all set by the
// single read port of the waiter memory with its registered output.
// Reset clears key valid bits, waiter counts and control; no clearing pass is needed.
// A stalled output holds the controller in its emit state until the word is taken.
module miss_fill_coalescer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [31:0] key_tag,
	input  logic        store_hit,
	input  logic [31:0] deadline,
	input  logic [31:0] current_time,
	input  logic [7:0]  requester,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  target,
	output logic [1:0]  status,
	output logic        last
);
	import mfc_pkg::*;

	mfc_cmd_t  cmd;
	mfc_stat_t stat;

	mfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mfc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.op           (op),
		.key_tag      (key_tag),
		.store_hit    (store_hit),
		.deadline     (deadline),
		.current_time (current_time),
		.requester    (requester),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.target       (target),
		.status       (status),
		.last         (last)
	);

endmodule
